// File: hdl/sspop_pkg.sv
package sspop_pkg;

  localparam int MAX_SIDE_DEF = 32;

  localparam int KIND_W   = 2;
  localparam int COORD_W  = 5;
  localparam int RAND_W   = 31;
  localparam int SIDE_W   = 6;
  localparam int REMAIN_W = 11;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 6'd32;

  localparam logic [KIND_W-1:0] KIND_INIT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FILL,
    OP_SET_FULL,
    OP_SET_CELL,
    OP_DIV_RND,
    OP_RD_PICK,
    OP_CAP_PICK,
    OP_DIV_SIDE,
    OP_CAP_RC,
    OP_RD_POS,
    OP_CAP_POS,
    OP_RD_LAST,
    OP_CAP_LAST,
    OP_WR1,
    OP_WR2,
    OP_RESULT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic hit;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              in_range;
    logic              side_zero;
    logic              count_zero;
    logic              div_busy;
    logic              fill_last;
    logic              pos_ok;
  } status_t;

endpackage

// File: hdl/sspop_ram.sv
module sspop_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/sspop_div.sv
module sspop_div #(
  parameter int NW = 31,
  parameter int DW = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          busy_o,
  output logic [NW-1:0] quotient_o,
  output logic [DW-1:0] remainder_o
);

  localparam int SW = $clog2(NW + 1);

  logic          busy_q, busy_d;
  logic [SW-1:0] step_q, step_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dvs_q, dvs_d;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic          ge;

  assign rem_sh = {rem_q, quo_q[NW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      quo_d  = {quo_q[NW-2:0], ge};
      step_d = step_q + SW'(1);
      if (step_q == SW'(NW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o      = busy_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// File: hdl/sspop_ctrl.sv
module sspop_ctrl
  import sspop_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_FILL      = 4'd2;
  localparam logic [3:0] S_FILL_END  = 4'd3;
  localparam logic [3:0] S_DIV1      = 4'd4;
  localparam logic [3:0] S_CAP_PICK  = 4'd5;
  localparam logic [3:0] S_DIV2      = 4'd6;
  localparam logic [3:0] S_DIV2_WAIT = 4'd7;
  localparam logic [3:0] S_RD_POS    = 4'd8;
  localparam logic [3:0] S_CAP_POS   = 4'd9;
  localparam logic [3:0] S_CHECK     = 4'd10;
  localparam logic [3:0] S_CAP_LAST  = 4'd11;
  localparam logic [3:0] S_WR1       = 4'd12;
  localparam logic [3:0] S_WR2       = 4'd13;
  localparam logic [3:0] S_DONE      = 4'd14;

  logic [3:0] state_q, state_d;
  logic       hit_q, hit_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    cmd_o.op    = OP_NONE;
    cmd_o.hit   = hit_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        hit_d   = 1'b0;
        state_d = S_DONE;
        case (status_i.kind)
          KIND_INIT: begin
            state_d = S_FILL;
          end
          KIND_REMOVE: begin
            if (status_i.in_range && !status_i.side_zero) begin
              cmd_o.op = OP_SET_CELL;
              state_d  = S_RD_POS;
            end
          end
          KIND_POP: begin
            if (!status_i.side_zero && !status_i.count_zero) begin
              cmd_o.op = OP_DIV_RND;
              state_d  = S_DIV1;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_FILL: begin
        cmd_o.op = OP_FILL;
        if (status_i.fill_last) begin
          state_d = S_FILL_END;
        end
      end
      S_FILL_END: begin
        cmd_o.op = OP_SET_FULL;
        hit_d    = 1'b1;
        state_d  = S_DONE;
      end
      S_DIV1: begin
        if (!status_i.div_busy) begin
          cmd_o.op = OP_RD_PICK;
          state_d  = S_CAP_PICK;
        end
      end
      S_CAP_PICK: begin
        cmd_o.op = OP_CAP_PICK;
        state_d  = S_DIV2;
      end
      S_DIV2: begin
        cmd_o.op = OP_DIV_SIDE;
        state_d  = S_DIV2_WAIT;
      end
      S_DIV2_WAIT: begin
        if (!status_i.div_busy) begin
          cmd_o.op = OP_CAP_RC;
          state_d  = S_RD_POS;
        end
      end
      S_RD_POS: begin
        cmd_o.op = OP_RD_POS;
        state_d  = S_CAP_POS;
      end
      S_CAP_POS: begin
        cmd_o.op = OP_CAP_POS;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        if (status_i.pos_ok) begin
          cmd_o.op = OP_RD_LAST;
          state_d  = S_CAP_LAST;
        end else begin
          hit_d   = 1'b0;
          state_d = S_DONE;
        end
      end
      S_CAP_LAST: begin
        cmd_o.op = OP_CAP_LAST;
        state_d  = S_WR1;
      end
      S_WR1: begin
        cmd_o.op = OP_WR1;
        state_d  = S_WR2;
      end
      S_WR2: begin
        cmd_o.op = OP_WR2;
        hit_d    = 1'b1;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = OP_RESULT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/sspop_dp.sv
module sspop_dp
  import sspop_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_wr_en_i,
  input  logic [SIDE_W-1:0]   cfg_wr_data_i,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [COORD_W-1:0]  row_i,
  input  logic [COORD_W-1:0]  col_i,
  input  logic [RAND_W-1:0]   random_value_i,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  output logic                hit_o,
  output logic [COORD_W-1:0]  out_row_o,
  output logic [COORD_W-1:0]  out_col_o,
  output logic [REMAIN_W-1:0] remaining_o
);

  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int KW    = $clog2(CELLS + 1);
  localparam int DW    = (KW > SIDE_W) ? KW : SIDE_W;
  localparam int LW    = 2 * SIDE_W;

  logic [SIDE_W-1:0]   side_q;
  logic [KW-1:0]       count_q;
  logic [KIND_W-1:0]   kind_q;
  logic [COORD_W-1:0]  row_q, col_q;
  logic [RAND_W-1:0]   rnd_q;
  logic [CW-1:0]       c_q, pos_q, last_q, fill_q;
  logic [COORD_W-1:0]  orow_q, ocol_q;
  logic                hit_q;
  logic [COORD_W-1:0]  out_row_q, out_col_q;
  logic [REMAIN_W-1:0] remaining_q;

  logic [SIDE_W-1:0]   side_eff;
  logic [LW-1:0]       side_sq;
  logic [LW-1:0]       lin;
  logic [KW-1:0]       count_dec;
  logic                pop_hit;

  logic                div_start;
  logic [RAND_W-1:0]   div_dividend;
  logic [DW-1:0]       div_divisor;
  logic                div_busy;
  logic [RAND_W-1:0]   div_quo;
  logic [DW-1:0]       div_rem;

  logic                cell_we, pos_we;
  logic [CW-1:0]       cell_waddr, cell_wdata, cell_raddr, cell_rdata;
  logic [CW-1:0]       pos_waddr, pos_wdata, pos_raddr, pos_rdata;

  assign side_eff  = (int'(side_q) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : side_q;
  assign side_sq   = LW'(side_eff) * LW'(side_eff);
  assign lin       = LW'(row_q) * LW'(side_eff) + LW'(col_q);
  assign count_dec = count_q - KW'(1);
  assign pop_hit   = cmd_i.hit && (kind_q == KIND_POP);

  assign div_start    = (cmd_i.op == OP_DIV_RND) || (cmd_i.op == OP_DIV_SIDE);
  assign div_dividend = (cmd_i.op == OP_DIV_SIDE) ? RAND_W'(c_q) : rnd_q;
  assign div_divisor  = (cmd_i.op == OP_DIV_SIDE) ? DW'(side_eff) : DW'(count_q);

  sspop_div #(
    .NW (RAND_W),
    .DW (DW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .busy_o      (div_busy),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    cell_we    = 1'b0;
    pos_we     = 1'b0;
    cell_waddr = fill_q;
    cell_wdata = fill_q;
    pos_waddr  = fill_q;
    pos_wdata  = fill_q;
    cell_raddr = (cmd_i.op == OP_RD_LAST) ? CW'(count_dec) : CW'(div_rem);
    pos_raddr  = c_q;
    unique case (cmd_i.op)
      OP_FILL: begin
        cell_we = 1'b1;
        pos_we  = 1'b1;
      end
      OP_WR1: begin
        cell_we    = 1'b1;
        cell_waddr = pos_q;
        cell_wdata = last_q;
        pos_we     = 1'b1;
        pos_waddr  = last_q;
        pos_wdata  = pos_q;
      end
      OP_WR2: begin
        cell_we    = 1'b1;
        cell_waddr = CW'(count_q);
        cell_wdata = c_q;
        pos_we     = 1'b1;
        pos_waddr  = c_q;
        pos_wdata  = CW'(count_q);
      end
      default: begin
        cell_we = 1'b0;
        pos_we  = 1'b0;
      end
    endcase
  end

  sspop_ram #(
    .WIDTH (CW),
    .DEPTH (CELLS)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .raddr_i (cell_raddr),
    .rdata_o (cell_rdata)
  );

  sspop_ram #(
    .WIDTH (CW),
    .DEPTH (CELLS)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q  <= SIDE_RESET;
      count_q <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        side_q <= cfg_wr_data_i;
      end
      if (cmd_i.op == OP_SET_FULL) begin
        count_q <= KW'(side_sq);
      end else if (cmd_i.op == OP_RD_LAST) begin
        count_q <= count_dec;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        kind_q <= kind_i;
        row_q  <= row_i;
        col_q  <= col_i;
        rnd_q  <= random_value_i;
        fill_q <= '0;
      end
      OP_FILL: begin
        fill_q <= fill_q + CW'(1);
      end
      OP_SET_CELL: begin
        c_q <= CW'(lin);
      end
      OP_CAP_PICK: begin
        c_q <= cell_rdata;
      end
      OP_CAP_RC: begin
        orow_q <= div_quo[COORD_W-1:0];
        ocol_q <= div_rem[COORD_W-1:0];
      end
      OP_CAP_POS: begin
        pos_q <= pos_rdata;
      end
      OP_CAP_LAST: begin
        last_q <= cell_rdata;
      end
      OP_RESULT: begin
        hit_q       <= cmd_i.hit;
        out_row_q   <= pop_hit ? orow_q : '0;
        out_col_q   <= pop_hit ? ocol_q : '0;
        remaining_q <= REMAIN_W'(count_q);
      end
      default: begin
      end
    endcase
  end

  assign status_o.kind       = kind_q;
  assign status_o.in_range   = ({1'b0, row_q} < side_eff) && ({1'b0, col_q} < side_eff);
  assign status_o.side_zero  = side_eff == '0;
  assign status_o.count_zero = count_q == '0;
  assign status_o.div_busy   = div_busy;
  assign status_o.fill_last  = fill_q == CW'(CELLS - 1);
  assign status_o.pos_ok     = KW'(pos_q) < count_q;

  assign hit_o       = hit_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign remaining_o = remaining_q;

endmodule

// File: hdl/sparse_set_random_pop.sv
// Sparse set of grid cells with remove and random pop, one transaction at a time.
// The input channel (in_valid_i, in_stall_o) carries kind, row, col and random_value.
// The output channel (out_valid_o, out_stall_i) returns one result transaction per
// input transaction: hit, out_row, out_col and the remaining member count.
// The user sets the grid side through cfg_wr_en_i and cfg_wr_data_i only while
// the block is idle; the block itself does not enforce this.
// The result is loaded into the output register as the block returns to idle.
// Init sweeps both maps, one entry per cycle.
// Remove reads both maps, then writes both in states WR1 and WR2; it ends
// without writes when the cell is not a member or lies outside the side.
// Pop runs two 31-step divisions in the shared bit-serial divider
// (random value modulo the count, then cell number by side) plus the map accesses.
// A pop on an empty set or with side zero, and kind three, skip to the result.
// The block holds in_stall_o high from acceptance until the result is loaded into
// the output register; the next transaction is accepted while that result waits.
// If the receiver stalls, the result holds and a following result waits inside the
// block until the output register is free.
// After reset the side is 32, the set is empty and the maps are undefined until the
// first init.
module sparse_set_random_pop
  import sspop_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_wr_en_i,
  input  logic [SIDE_W-1:0]   cfg_wr_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [COORD_W-1:0]  row_i,
  input  logic [COORD_W-1:0]  col_i,
  input  logic [RAND_W-1:0]   random_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                hit_o,
  output logic [COORD_W-1:0]  out_row_o,
  output logic [COORD_W-1:0]  out_col_o,
  output logic [REMAIN_W-1:0] remaining_o
);

  cmd_t    cmd;
  status_t status;

  sspop_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sspop_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_wr_data_i  (cfg_wr_data_i),
    .kind_i         (kind_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .random_value_i (random_value_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .hit_o          (hit_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .remaining_o    (remaining_o)
  );

endmodule
